FILE: rtl/wrhp_pkg.sv
// Package for the WAV/RF64 header parser: parse phases, chunk identifiers,
// status codes and the front-to-back word type. No dependencies.
`default_nettype none
package wrhp_pkg;
    localparam int HeaderBytes = 65536;
    localparam int PosWidth = 17;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_CHDR = 3'd1,
        PH_SKIP = 3'd2,
        PH_FMT  = 3'd3,
        PH_DS64 = 3'd4,
        PH_HALT = 3'd5
    } t_phase;

    localparam logic [31:0] ID_RIFF = 32'h52494646;
    localparam logic [31:0] ID_RF64 = 32'h52463634;
    localparam logic [31:0] ID_WAVE = 32'h57415645;
    localparam logic [31:0] ID_FMT  = 32'h666D7420;
    localparam logic [31:0] ID_DATA = 32'h64617461;
    localparam logic [31:0] ID_DS64 = 32'h64733634;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_TAG  = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       take;
    } t_word;
endpackage
`default_nettype wire

FILE: rtl/wav_rf64_header_parser_top.sv
// Top level of the WAV/RF64 header parser: front, queue and back parts.
// Depends on wrhp_pkg, wrhp_front, wrhp_fifo and wrhp_back.
// One word is accepted per cycle and the back part walks one byte per cycle,
// both unless stalled. The result is registered in the back part when the
// word marked last leaves the queue. Synchronous active-low reset clears all
// control state; parsing restarts after every result.
`default_nettype none
module wav_rf64_header_parser_top #(
    parameter int HEADER_BYTES = wrhp_pkg::HeaderBytes
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // header_byte
    input  wire          s_axis_tlast,   // end_of_header
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // status[1:0], is_rf64[2], channel_count[18:3], sample_rate_hz[50:19],
    // sample_bits[66:51], payload_offset[83:67], payload_size[147:84], zero fill
    output logic [151:0] m_axis_tdata
);
    wrhp_pkg::t_word w_fw, w_qw;
    logic w_fv, w_fr, w_qv, w_qr;
    logic [1:0] st;
    logic rf;
    logic [15:0] ch, bits;
    logic [31:0] rate;
    logic [16:0] off;
    logic [63:0] sz;

    wrhp_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .i_last(s_axis_tlast),
        .o_valid(w_fv), .i_ready(w_fr), .o_word(w_fw));
    wrhp_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_word(w_fw),
        .o_valid(w_qv), .i_ready(w_qr), .o_word(w_qw));
    wrhp_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_word(w_qw),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_status(st),
        .o_is_rf64(rf), .o_channel_count(ch), .o_sample_rate_hz(rate),
        .o_sample_bits(bits), .o_payload_offset(off), .o_payload_size(sz));

    assign m_axis_tdata = {4'd0, sz, off, bits, rate, ch, rf, st};
endmodule
`default_nettype wire

FILE: rtl/wrhp_front.sv
// Front part of the header parser: accepts input words and marks whether each
// still falls within the header window. Depends on wrhp_pkg.
`default_nettype none
module wrhp_front #(
    parameter int HEADER_BYTES = wrhp_pkg::HeaderBytes
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [7:0]         i_data,
    input  wire                i_last,
    output logic               o_valid,
    input  wire                i_ready,
    output wrhp_pkg::t_word    o_word
);
    localparam int CntW = $clog2(HEADER_BYTES + 1);
    logic [CntW-1:0] r_count, n_count;
    logic            r_valid;
    wrhp_pkg::t_word r_word;
    logic            w_acc;

    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_count = r_count;
        if (w_acc) begin
            if (i_last) begin
                n_count = '0;
            end else if (r_count < CntW'(HEADER_BYTES)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (o_ready) r_valid <= i_valid;
        end
        if (w_acc) begin
            r_word.data <= i_data;
            r_word.last <= i_last;
            r_word.take <= r_count < CntW'(HEADER_BYTES);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/wrhp_fifo.sv
// Two-entry queue between front and back of the header parser.
// Depends on wrhp_pkg.
`default_nettype none
module wrhp_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  wrhp_pkg::t_word i_word,
    output logic            o_valid,
    input  wire             i_ready,
    output wrhp_pkg::t_word o_word
);
    wrhp_pkg::t_word r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_word  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_word;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("queue full but ready");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt != 2'd0) else $error("push lost");
endmodule
`default_nettype wire

FILE: rtl/wrhp_back.sv
// Back part of the header parser: walks the chunks, captures the fmt, data
// and ds64 fields and forms the status word. Depends on wrhp_pkg.
`default_nettype none
module wrhp_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wrhp_pkg::t_word  i_word,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [1:0]       o_status,
    output logic             o_is_rf64,
    output logic [15:0]      o_channel_count,
    output logic [31:0]      o_sample_rate_hz,
    output logic [15:0]      o_sample_bits,
    output logic [16:0]      o_payload_offset,
    output logic [63:0]      o_payload_size
);
    wrhp_pkg::t_phase r_ph, n_ph;
    logic [16:0] r_pos, n_pos;
    logic [31:0] r_tag, n_tag, r_csz, n_csz;
    logic [32:0] r_idx, n_idx;
    logic [15:0] r_ftag, n_ftag, r_ch, n_ch, r_bits, n_bits;
    logic [31:0] r_rate, n_rate, r_ksz, n_ksz;
    logic [16:0] r_off, n_off;
    logic [63:0] r_ds, n_ds;
    logic        r_riff, n_riff, r_rf64, n_rf64, r_ffmt, n_ffmt;
    logic        r_fdata, n_fdata, r_fds, n_fds, r_err2, n_err2, r_full, n_full;
    logic        r_ovalid;
    logic        w_acc;
    logic [32:0] w_blen;
    logic [31:0] w_shift, w_csz;
    logic [32:0] w_inext;
    logic [7:0]  b;
    logic [1:0]  f_st;
    logic [15:0] f_ch, f_bits;
    logic [31:0] f_rate;
    logic [63:0] f_ds;
    logic        f_err2;

    assign o_ready = !r_ovalid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign b       = i_word.data;
    assign w_blen  = {1'b0, r_csz} + {32'd0, r_csz[0]};
    assign w_shift = {r_tag[23:0], b};
    assign w_inext = r_idx + 33'd1;

    always_comb begin
        n_ph = r_ph; n_pos = r_pos; n_tag = r_tag; n_csz = r_csz; n_idx = r_idx;
        n_ftag = r_ftag; n_ch = r_ch; n_bits = r_bits; n_rate = r_rate;
        n_ksz = r_ksz; n_off = r_off; n_ds = r_ds; n_riff = r_riff;
        n_rf64 = r_rf64; n_ffmt = r_ffmt; n_fdata = r_fdata; n_fds = r_fds;
        n_err2 = r_err2; n_full = r_full;
        w_csz = r_csz;
        if (w_acc && i_word.take) begin
            if (r_pos == 17'd43) n_full = 1'b1;
            n_pos = r_pos + 17'd1;
            unique case (r_ph)
                wrhp_pkg::PH_SIG: begin
                    if (r_pos < 17'd4 || r_pos >= 17'd8) n_tag = w_shift;
                    if (r_pos == 17'd3) begin
                        if (w_shift == wrhp_pkg::ID_RIFF) n_riff = 1'b1;
                        else if (w_shift == wrhp_pkg::ID_RF64) n_rf64 = 1'b1;
                        n_tag = '0;
                    end
                    if (r_pos == 17'd11) begin
                        if (w_shift != wrhp_pkg::ID_WAVE) begin
                            n_riff = 1'b0; n_rf64 = 1'b0;
                        end
                        n_tag = '0; n_idx = '0; n_ph = wrhp_pkg::PH_CHDR;
                    end
                end
                wrhp_pkg::PH_CHDR: begin
                    if (r_idx < 33'd4) begin
                        n_tag = w_shift;
                    end else begin
                        case (r_idx[1:0])
                            2'd0: w_csz = {24'd0, b};
                            2'd1: w_csz = {r_csz[31:16], b, r_csz[7:0]};
                            2'd2: w_csz = {r_csz[31:24], b, r_csz[15:0]};
                            default: w_csz = {b, r_csz[23:0]};
                        endcase
                        n_csz = w_csz;
                    end
                    n_idx = w_inext;
                    if (r_idx == 33'd7) begin
                        n_idx = '0;
                        n_ph = wrhp_pkg::PH_SKIP;
                        if (r_tag == wrhp_pkg::ID_FMT) begin
                            if (w_csz >= 32'd16) begin
                                n_ph = wrhp_pkg::PH_FMT;
                                n_ftag = '0; n_ch = '0; n_rate = '0; n_bits = '0;
                            end
                        end else if (r_tag == wrhp_pkg::ID_DATA) begin
                            n_fdata = 1'b1;
                            n_off = r_pos + 17'd1;
                            if (!r_rf64) n_ksz = w_csz;
                        end else if (r_tag == wrhp_pkg::ID_DS64) begin
                            n_fds = 1'b1;
                            if (w_csz >= 32'd24) begin
                                n_ph = wrhp_pkg::PH_DS64; n_ds = '0;
                            end
                        end
                        if (w_csz == 32'd0) begin
                            n_ph = wrhp_pkg::PH_CHDR; n_tag = '0;
                        end
                    end
                end
                wrhp_pkg::PH_SKIP, wrhp_pkg::PH_FMT, wrhp_pkg::PH_DS64: begin
                    if (r_ph == wrhp_pkg::PH_FMT) begin
                        if (r_idx == 33'd0) n_ftag[7:0] = b;
                        if (r_idx == 33'd1) n_ftag[15:8] = b;
                        if (r_idx == 33'd2) n_ch[7:0] = b;
                        if (r_idx == 33'd3) n_ch[15:8] = b;
                        if (r_idx == 33'd4) n_rate[7:0] = b;
                        if (r_idx == 33'd5) n_rate[15:8] = b;
                        if (r_idx == 33'd6) n_rate[23:16] = b;
                        if (r_idx == 33'd7) n_rate[31:24] = b;
                        if (r_idx == 33'd14) n_bits[7:0] = b;
                        if (r_idx == 33'd15) n_bits[15:8] = b;
                    end
                    if (r_ph == wrhp_pkg::PH_DS64 && r_idx >= 33'd8 && r_idx < 33'd16) begin
                        n_ds[8*r_idx[2:0] +: 8] = b;
                    end
                    n_idx = w_inext;
                    if (w_inext >= w_blen) begin
                        n_ph = wrhp_pkg::PH_CHDR; n_idx = '0; n_tag = '0;
                    end
                    if (r_ph == wrhp_pkg::PH_FMT && r_idx == 33'd1) begin
                        if (n_ftag == 16'd1 || n_ftag == 16'd3 ||
                            n_ftag == 16'd6 || n_ftag == 16'd7) begin
                            n_ffmt = 1'b1;
                        end else begin
                            n_err2 = 1'b1; n_ph = wrhp_pkg::PH_HALT;
                            n_idx = w_inext;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        f_ch = n_ch; f_rate = n_rate; f_bits = n_bits; f_ds = n_ds;
        f_err2 = n_err2;
        if (n_ph == wrhp_pkg::PH_FMT) begin
            if (n_idx < 33'd2) f_err2 = 1'b1;
            if (n_idx < 33'd4) f_ch = '0;
            if (n_idx < 33'd8) f_rate = '0;
            if (n_idx < 33'd16) f_bits = '0;
        end else if (n_ph == wrhp_pkg::PH_DS64) begin
            if (n_idx < 33'd16) f_ds = '0;
        end
        if (!n_full || !(n_riff || n_rf64)) f_st = wrhp_pkg::ST_BAD;
        else if (f_err2) f_st = wrhp_pkg::ST_TAG;
        else if (!n_ffmt || !n_fdata) f_st = wrhp_pkg::ST_BAD;
        else f_st = wrhp_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_word.last)) begin
            r_ph <= wrhp_pkg::PH_SIG; r_pos <= '0; r_tag <= '0; r_csz <= '0;
            r_idx <= '0; r_ftag <= '0; r_ch <= '0; r_bits <= '0; r_rate <= '0;
            r_ksz <= '0; r_off <= '0; r_ds <= '0; r_riff <= 1'b0;
            r_rf64 <= 1'b0; r_ffmt <= 1'b0; r_fdata <= 1'b0; r_fds <= 1'b0;
            r_err2 <= 1'b0; r_full <= 1'b0;
        end else begin
            r_ph <= n_ph; r_pos <= n_pos; r_tag <= n_tag; r_csz <= n_csz;
            r_idx <= n_idx; r_ftag <= n_ftag; r_ch <= n_ch; r_bits <= n_bits;
            r_rate <= n_rate; r_ksz <= n_ksz; r_off <= n_off; r_ds <= n_ds;
            r_riff <= n_riff; r_rf64 <= n_rf64; r_ffmt <= n_ffmt;
            r_fdata <= n_fdata; r_fds <= n_fds; r_err2 <= n_err2; r_full <= n_full;
        end
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_ready) begin
            r_ovalid <= w_acc && i_word.last;
        end
        if (w_acc && i_word.last) begin
            o_status <= f_st;
            o_is_rf64 <= (f_st == wrhp_pkg::ST_OK) && n_rf64;
            o_channel_count <= (f_st == wrhp_pkg::ST_OK) ? f_ch : '0;
            o_sample_rate_hz <= (f_st == wrhp_pkg::ST_OK) ? f_rate : '0;
            o_sample_bits <= (f_st == wrhp_pkg::ST_OK) ? f_bits : '0;
            o_payload_offset <= (f_st == wrhp_pkg::ST_OK) ? n_off : '0;
            o_payload_size <= (f_st != wrhp_pkg::ST_OK) ? 64'd0 :
                              n_rf64 ? (n_fds ? f_ds : 64'd0) : {32'd0, n_ksz};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != wrhp_pkg::ST_OK |-> o_payload_size == 64'd0)
        else $error("error result carries data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == wrhp_pkg::ST_OK |-> o_payload_offset >= 17'd20)
        else $error("ok result with impossible offset");
endmodule
`default_nettype wire
